[rtl/ppsi_pkg.sv]
// Shared types for the prime partition / sort / interleave block.
// Command and status bundles between controller and datapath; no dependencies.
package ppsi_pkg;

    typedef struct packed {
        logic load;       // capture input word, reset trial divisor
        logic mod_start;  // begin remainder of value by divisor
        logic mod_step;   // one restoring step
        logic d_inc;      // next divisor
        logic ins_init;   // start insertion into a group
        logic ins_prime;  // group for ins_init: 1 = primes
        logic ins_rd;     // read neighbor below insertion point
        logic ins_shift;  // move neighbor up one slot
        logic ins_put;    // write key, bump group count
        logic em_init;    // start emission
        logic em_rd;      // pick group, read next entry
        logic em_ld;      // load output register
        logic clr;        // both counts back to zero
    } ppsi_cmd_t;

    typedef struct packed {
        logic full;       // stores hold the maximum item count
        logic below_two;  // value below two
        logic sq_gt;      // divisor squared exceeds value
        logic mod_done;
        logic rem_zero;
        logic j_zero;     // insertion point at slot zero
        logic move;       // neighbor belongs above the key
        logic last;       // captured last mark
        logic em_done;    // no more words to emit
    } ppsi_stat_t;

endpackage

[rtl/ppsi_dp.sv]
// Datapath: sorted stores, trial-division unit, emission counters, output register.
// Depends on ppsi_pkg; driven by ppsi_ctrl.
module ppsi_dp #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         value,
    input  logic                last_in,
    input  ppsi_pkg::ppsi_cmd_t cmd,
    output ppsi_pkg::ppsi_stat_t stat,
    output logic [15:0]         out_value,
    output logic                last_out
);
    localparam int VB = VALUE_BITS;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int MW = $clog2(VB + 1);

    logic [VB-1:0] pmem [MAX_ITEMS];
    logic [VB-1:0] omem [MAX_ITEMS];
    logic [VB-1:0] prd_reg, ord_reg;

    logic [VB-1:0] v_reg, d_reg, rem_reg, sh_reg;
    logic [VB:0]   dsq_reg;
    logic [MW-1:0] mcnt_reg;
    logic          last_reg, grp_reg, sel_reg;
    logic [CW-1:0] pcnt_reg, ocnt_reg, j_reg, p_reg, q_reg, left_reg;
    logic [1:0]    m3_reg;
    logic [15:0]   out_value_reg;
    logic          last_out_reg;

    logic [CW:0]   total;
    logic [CW-1:0] jm1, left_dec;
    logic [VB:0]   t, t_sub;
    logic [VB-1:0] grd;
    logic          take_prime;
    logic [AW-1:0] prd_addr, ord_addr;

    assign total    = {1'b0, pcnt_reg} + {1'b0, ocnt_reg};
    assign jm1      = j_reg - 1'b1;
    assign left_dec = left_reg - 1'b1;
    assign t        = {rem_reg, sh_reg[VB-1]};
    assign t_sub    = t - {1'b0, d_reg};
    assign grd      = grp_reg ? prd_reg : ord_reg;
    assign take_prime = ((m3_reg != 2'd2) && (p_reg < pcnt_reg)) || (q_reg >= ocnt_reg);

    always_comb
    begin
        prd_addr = jm1[AW-1:0];
        ord_addr = jm1[AW-1:0];
        if (cmd.em_rd)
        begin
            prd_addr = p_reg[AW-1:0];
            ord_addr = q_reg[AW-1:0];
        end
    end

    assign stat.full      = total >= (CW+1)'(MAX_ITEMS);
    assign stat.below_two = v_reg < VB'(2);
    assign stat.sq_gt     = dsq_reg > {1'b0, v_reg};
    assign stat.mod_done  = mcnt_reg == '0;
    assign stat.rem_zero  = rem_reg == '0;
    assign stat.j_zero    = j_reg == '0;
    assign stat.move      = grp_reg ? (grd > v_reg) : (grd < v_reg);
    assign stat.last      = last_reg;
    assign stat.em_done   = left_reg == '0;

    // stores: one write, one registered read each
    always_ff @(posedge clk)
    begin
        prd_reg <= pmem[prd_addr];
        ord_reg <= omem[ord_addr];
        if ((cmd.ins_shift || cmd.ins_put) && grp_reg)
            pmem[j_reg[AW-1:0]] <= cmd.ins_shift ? prd_reg : v_reg;
        if ((cmd.ins_shift || cmd.ins_put) && !grp_reg)
            omem[j_reg[AW-1:0]] <= cmd.ins_shift ? ord_reg : v_reg;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg    <= VB'(value);
            last_reg <= last_in;
            d_reg    <= VB'(2);
            dsq_reg  <= (VB+1)'(4);
        end
        if (cmd.d_inc)
        begin
            d_reg   <= d_reg + 1'b1;
            dsq_reg <= dsq_reg + {d_reg, 1'b1};
        end
        if (cmd.mod_start)
        begin
            rem_reg  <= '0;
            sh_reg   <= v_reg;
            mcnt_reg <= MW'(VB);
        end
        if (cmd.mod_step)
        begin
            // t < 2*d, so one compare and subtract
            rem_reg  <= (t >= {1'b0, d_reg}) ? t_sub[VB-1:0] : t[VB-1:0];
            sh_reg   <= sh_reg << 1;
            mcnt_reg <= mcnt_reg - 1'b1;
        end
        if (cmd.ins_init)
        begin
            grp_reg <= cmd.ins_prime;
            j_reg   <= cmd.ins_prime ? pcnt_reg : ocnt_reg;
        end
        if (cmd.ins_shift)
            j_reg <= jm1;
        if (cmd.em_init)
        begin
            p_reg    <= '0;
            q_reg    <= '0;
            m3_reg   <= '0;
            left_reg <= total[CW-1:0];
        end
        if (cmd.em_rd)
        begin
            sel_reg  <= take_prime;
            m3_reg   <= (m3_reg == 2'd2) ? 2'd0 : m3_reg + 1'b1;
            left_reg <= left_dec;
            if (take_prime)
                p_reg <= p_reg + 1'b1;
            else
                q_reg <= q_reg + 1'b1;
        end
        if (cmd.em_ld)
        begin
            out_value_reg <= 16'(sel_reg ? prd_reg : ord_reg);
            last_out_reg  <= left_reg == '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg <= '0;
            ocnt_reg <= '0;
        end
        else if (cmd.clr)
        begin
            pcnt_reg <= '0;
            ocnt_reg <= '0;
        end
        else if (cmd.ins_put)
        begin
            if (grp_reg)
                pcnt_reg <= pcnt_reg + 1'b1;
            else
                ocnt_reg <= ocnt_reg + 1'b1;
        end
    end

    assign out_value = out_value_reg;
    assign last_out  = last_out_reg;

endmodule

[rtl/ppsi_ctrl.sv]
// Controller: sequences classify, trial division, sorted insert and emission.
// Depends on ppsi_pkg; commands ppsi_dp.
module ppsi_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ppsi_pkg::ppsi_stat_t stat,
    output ppsi_pkg::ppsi_cmd_t  cmd
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_CLASS, ST_TCHK, ST_TMOD, ST_INS_CHK, ST_INS_CMP,
        ST_EM_INIT, ST_EM_RD, ST_EM_LD, ST_EM_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASS;
                end
            ST_CLASS:
                if (stat.full)
                    state_next = stat.last ? ST_EM_INIT : ST_IDLE;
                else if (stat.below_two)
                begin
                    cmd.ins_init = 1'b1;
                    state_next   = ST_INS_CHK;
                end
                else
                    state_next = ST_TCHK;
            ST_TCHK:
                if (stat.sq_gt)
                begin
                    cmd.ins_init  = 1'b1;
                    cmd.ins_prime = 1'b1;
                    state_next    = ST_INS_CHK;
                end
                else
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = ST_TMOD;
                end
            ST_TMOD:
                if (!stat.mod_done)
                    cmd.mod_step = 1'b1;
                else if (stat.rem_zero)
                begin
                    cmd.ins_init = 1'b1;
                    state_next   = ST_INS_CHK;
                end
                else
                begin
                    cmd.d_inc  = 1'b1;
                    state_next = ST_TCHK;
                end
            ST_INS_CHK:
                if (stat.j_zero)
                begin
                    cmd.ins_put = 1'b1;
                    state_next  = stat.last ? ST_EM_INIT : ST_IDLE;
                end
                else
                begin
                    cmd.ins_rd = 1'b1;
                    state_next = ST_INS_CMP;
                end
            ST_INS_CMP:
                if (stat.move)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = ST_INS_CHK;
                end
                else
                begin
                    cmd.ins_put = 1'b1;
                    state_next  = stat.last ? ST_EM_INIT : ST_IDLE;
                end
            ST_EM_INIT:
            begin
                cmd.em_init = 1'b1;
                state_next  = ST_EM_RD;
            end
            ST_EM_RD:
            begin
                cmd.em_rd  = 1'b1;
                state_next = ST_EM_LD;
            end
            ST_EM_LD:
            begin
                cmd.em_ld      = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_EM_OUT;
            end
            ST_EM_OUT:
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (stat.em_done)
                    begin
                        cmd.clr    = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_EM_RD;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;

endmodule

[rtl/prime_partition_sort_interleave.sv]
// Prime partition / sort / interleave: top level joining ppsi_ctrl and ppsi_dp.
// Depends on ppsi_pkg.
//
// Takes a list one word at a time (last_in marks the end), sorts primes ascending and
// non-primes descending as they arrive, then emits the list two primes to one non-prime,
// either group filling in once the other is empty. One word is handled at a time. Each
// trial divisor up to a word's square root runs through the bit-serial remainder unit,
// and the sorted insert moves entries up one slot at a time. Emission has a setup step,
// then reads, loads and offers each output word, holding it while the output stalls.
// Words beyond MAX_ITEMS are dropped.
module prime_partition_sort_interleave #(
    parameter int MAX_ITEMS  = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] value,
    input  logic        last_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_value,
    output logic        last_out
);
    ppsi_pkg::ppsi_cmd_t  cmd;
    ppsi_pkg::ppsi_stat_t stat;

    ppsi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ppsi_dp #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .last_in   (last_in),
        .cmd       (cmd),
        .stat      (stat),
        .out_value (out_value),
        .last_out  (last_out)
    );

endmodule

[sim/prime_partition_sort_interleave_tb.sv]
// Testbench for prime_partition_sort_interleave: random and directed lists, a local
// predictor of the partition / sort / interleave order, and a checker on every output word.
// Depends on rtl/prime_partition_sort_interleave.sv.
`timescale 1ns / 1ps

module prime_partition_sort_interleave_tb;

    localparam int LIST_MAX   = 64;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic [15:0] val;
        logic        last;
    } word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] value = '0;
    logic        last_in = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] out_value;
    logic        last_out;

    logic [15:0] primes_held[$];
    logic [15:0] others_held[$];
    word_t       expected_words[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    bit          stim_done = 1'b0;

    prime_partition_sort_interleave i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .value(value), .last_in(last_in),
        .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
        .last_out(last_out)
    );

    always #5 clk = ~clk;

    function automatic bit is_prime_val(int unsigned v);
        int unsigned d;
        if (v < 2)
            return 1'b0;
        for (d = 2; d <= v / d; d++)
            if (v % d == 0)
                return 1'b0;
        return 1'b1;
    endfunction

    // store the word, and on the last mark queue the interleaved list
    task automatic predict_list_word(logic [15:0] v, logic lst);
        int total;
        int p;
        int q;
        bit take_prime;
        p = 0;
        q = 0;
        if (primes_held.size() + others_held.size() < LIST_MAX)
        begin
            if (is_prime_val(32'(v)))
                primes_held.push_back(v);
            else
                others_held.push_back(v);
        end
        if (!lst)
            return;
        primes_held.sort();
        others_held.rsort();
        total = primes_held.size() + others_held.size();
        for (int i = 0; i < total; i++)
        begin
            take_prime = ((i % 3) < 2 && p < primes_held.size()) || q >= others_held.size();
            if (take_prime)
                expected_words.push_back('{primes_held[p++], i == total - 1});
            else
                expected_words.push_back('{others_held[q++], i == total - 1});
        end
        primes_held.delete();
        others_held.delete();
    endtask

    // valid is dropped only for a gap; the caller drops it after the final word
    task automatic send_word(logic [15:0] v, logic lst);
        // random gaps between bursts
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        value    <= v;
        last_in  <= lst;
        do @(posedge clk); while (!in_ready);
        predict_list_word(v, lst);
        @(negedge clk);
    endtask

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 3));
            1: return 16'($urandom_range(0, 200));
            2: return 16'hffff - 16'($urandom_range(0, 40));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic test_edge_values();
        send_word(16'd0, 1'b1);
        send_word(16'd1, 1'b0);
        send_word(16'd2, 1'b0);
        send_word(16'd3, 1'b0);
        send_word(16'd4, 1'b0);
        send_word(16'hffff, 1'b0);
        send_word(16'hfff1, 1'b0);   // 65521, largest 16-bit prime
        send_word(16'd65519, 1'b1);
        send_word(16'd7, 1'b1);
        // primes only, then non-primes only: one group runs dry
        send_word(16'd13, 1'b0);
        send_word(16'd5, 1'b0);
        send_word(16'd11, 1'b1);
        send_word(16'd9, 1'b0);
        send_word(16'd8, 1'b0);
        send_word(16'd25, 1'b1);
    endtask

    task automatic test_overflow();
        // more than LIST_MAX words; the late last mark is dropped but still flushes
        for (int i = 0; i < LIST_MAX + 3; i++)
            send_word(rand_value(), i == LIST_MAX + 2);
    endtask

    task automatic test_random_lists();
        int len;
        int sent;
        sent = 0;
        while (sent < 110)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_word(rand_value(), i == len - 1);
            sent += len;
        end
    endtask

    // receiver stall pattern
    always @(negedge clk)
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 3) != 0) || stim_done;

    always @(posedge clk)
    begin
        word_t exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: value=%0d last=%0b", out_value, last_out);
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (out_value !== exp_w.val || last_out !== exp_w.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0b, got %0d/%0b",
                                 exp_w.val, exp_w.last, out_value, last_out);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("prime_partition_sort_interleave_tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_edge_values();
        test_overflow();
        test_random_lists();
        in_valid  <= 1'b0;
        stim_done = 1'b1;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("prime_partition_sort_interleave_tb: PASS");
        else
            $display("prime_partition_sort_interleave_tb: FAIL");
        $finish;
    end

endmodule
